[rtl/rari_pkg.sv]
package rari_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  // Quotient magnitude bits for t: |num| < 2^49, and |t| <= far_limit < 2^31 matters,
  // but the full quotient can reach 2^49, so the divider runs 50 steps.
  localparam int TQ = 50;
  localparam int TD = 49;
  localparam int UQ = 17;
  localparam int UD = 50;

  typedef enum logic [2:0] {
    REG_AXIS   = 3'd0,
    REG_F_LO   = 3'd1,
    REG_F_HI   = 3'd2,
    REG_S_LO   = 3'd3,
    REG_S_HI   = 3'd4,
    REG_PLANE  = 3'd5,
    REG_NEAR   = 3'd6,
    REG_MAT    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        axis;
    logic signed [31:0] f_lo;
    logic signed [31:0] f_hi;
    logic signed [31:0] s_lo;
    logic signed [31:0] s_hi;
    logic signed [31:0] plane;
    logic [30:0]       near_lim;
    logic [7:0]        mat;
  } cfg_t;

  // One restoring-division cell: shift in one numerator bit, trial subtract.
  typedef struct packed {
    logic [TQ-1:0] num;
    logic [TD:0]   rem;
    logic [TD-1:0] den;
  } tdiv_t;

  typedef struct packed {
    logic [UQ-1:0] num;
    logic [UD:0]   rem;
    logic [UD-1:0] den;
  } udiv_t;

  typedef struct packed {
    logic              miss;
    logic              neg;
    logic              front;
    logic [1:0]        axis;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [30:0]       far_lim;
    logic [30:0]       near_lim;
    logic signed [31:0] f_lo;
    logic signed [31:0] f_hi;
    logic signed [31:0] s_lo;
    logic signed [31:0] s_hi;
    logic [7:0]        mat;
  } tctx_t;

  typedef struct packed {
    logic              miss;
    logic              front;
    logic [7:0]        mat;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic              zu;
    logic              zv;
  } uctx_t;

endpackage

[rtl/rari_if.sv]
interface rari_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [30:0]        far_limit;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  far_limit, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                far_limit, output ready);
endinterface

interface rari_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;
  logic [16:0]        coord_u;
  logic [16:0]        coord_v;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               front_face;
  logic [7:0]         material_out;
  modport source (output valid, hit, distance, coord_u, coord_v, point_x, point_y,
                  point_z, front_face, material_out, input ready);
  modport sink (input valid, hit, distance, coord_u, coord_v, point_x, point_y,
                point_z, front_face, material_out, output ready);
endinterface

[rtl/rari_tdiv_cell.sv]
// One quotient bit of the distance division per cell, carrying the ray context along.
module rari_tdiv_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  input  rari_pkg::tdiv_t      din,
  input  rari_pkg::tctx_t      cin,
  output logic                 vout,
  output rari_pkg::tdiv_t      dout,
  output rari_pkg::tctx_t      cout
);
  logic [rari_pkg::TD:0]   sh;
  logic [rari_pkg::TD+1:0] diff;
  rari_pkg::tdiv_t         nx;

  always_comb begin
    sh   = {din.rem[rari_pkg::TD-1:0], din.num[rari_pkg::TQ-1]};
    diff = {1'b0, sh} - {2'b00, din.den};
    nx.den = din.den;
    if (!diff[rari_pkg::TD+1]) begin
      nx.rem = diff[rari_pkg::TD:0];
      nx.num = {din.num[rari_pkg::TQ-2:0], 1'b1};
    end else begin
      nx.rem = sh;
      nx.num = {din.num[rari_pkg::TQ-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= nx;
      cout <= cin;
    end
  end
endmodule

[rtl/rari_udiv_cell.sv]
// One quotient bit of the u and v divisions per cell.
module rari_udiv_cell (
  input  logic             clk,
  input  logic             en,
  input  rari_pkg::udiv_t  ui,
  input  rari_pkg::udiv_t  vi,
  input  rari_pkg::uctx_t  cin,
  output rari_pkg::udiv_t  uo,
  output rari_pkg::udiv_t  vo,
  output rari_pkg::uctx_t  cout
);
  function automatic rari_pkg::udiv_t step(rari_pkg::udiv_t d);
    logic [rari_pkg::UD:0]   sh;
    logic [rari_pkg::UD+1:0] diff;
    rari_pkg::udiv_t         r;
    sh   = {d.rem[rari_pkg::UD-1:0], d.num[rari_pkg::UQ-1]};
    diff = {1'b0, sh} - {2'b00, d.den};
    r.den = d.den;
    if (!diff[rari_pkg::UD+1]) begin
      r.rem = diff[rari_pkg::UD:0];
      r.num = {d.num[rari_pkg::UQ-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.num = {d.num[rari_pkg::UQ-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      uo   <= step(ui);
      vo   <= step(vi);
      cout <= cin;
    end
  end
endmodule

[rtl/ray_axis_rect_intersect_top.sv]
// Fully pipelined ray/rectangle intersector: one ray per cycle unless output stalls.
// Each ray passes through an input register, a chain of 50 one-bit division
// cells for the hit distance, limit, multiply and point stages, a bound-check stage,
// 17 cells that divide u and v together, and the output register. The whole chain
// advances whenever the output register is empty or being taken. Configuration is
// sampled as a ray enters.
module ray_axis_rect_intersect_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  rari_in_if.sink         in_ch,
  rari_out_if.source      out_ch
);
  localparam int NT = rari_pkg::TQ;
  localparam int NU = rari_pkg::UQ;

  rari_pkg::cfg_t cfg;
  logic en;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis     <= 2'd2;
      cfg.f_lo     <= '0;
      cfg.f_hi     <= 32'sd65536;
      cfg.s_lo     <= '0;
      cfg.s_hi     <= 32'sd65536;
      cfg.plane    <= '0;
      cfg.near_lim <= 31'd66;
      cfg.mat      <= '0;
    end else if (cfg_we) begin
      case (rari_pkg::reg_idx_t'(cfg_index))
        rari_pkg::REG_AXIS:  cfg.axis     <= cfg_data[1:0];
        rari_pkg::REG_F_LO:  cfg.f_lo     <= cfg_data;
        rari_pkg::REG_F_HI:  cfg.f_hi     <= cfg_data;
        rari_pkg::REG_S_LO:  cfg.s_lo     <= cfg_data;
        rari_pkg::REG_S_HI:  cfg.s_hi     <= cfg_data;
        rari_pkg::REG_PLANE: cfg.plane    <= cfg_data;
        rari_pkg::REG_NEAR:  cfg.near_lim <= cfg_data[30:0];
        rari_pkg::REG_MAT:   cfg.mat      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Setup: numerator and divisor magnitudes.
  logic signed [31:0] on, dn;
  logic signed [33:0] diffn;
  logic [48:0]        nmag;
  logic [31:0]        dmag;
  logic               acc;
  rari_pkg::tdiv_t    td [0:NT];
  rari_pkg::tctx_t    tc [0:NT];
  logic               tv [0:NT];

  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    case (cfg.axis)
      2'd0:    begin on = in_ch.origin_x; dn = in_ch.dir_x; end
      2'd1:    begin on = in_ch.origin_y; dn = in_ch.dir_y; end
      default: begin on = in_ch.origin_z; dn = in_ch.dir_z; end
    endcase
    diffn = 34'(cfg.plane) - 34'(on);
    nmag  = diffn[33] ? 49'(-diffn) << 16 : 49'(diffn) << 16;
    dmag  = dn[31] ? 32'(-dn) : 32'(dn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else if (en) begin
      tv[0] <= acc;
    end
    if (en) begin
      td[0].num <= {1'b0, nmag};
      td[0].rem <= '0;
      td[0].den <= 49'(dmag);
      tc[0].miss     <= (dn == 0);
      tc[0].neg      <= diffn[33] ^ dn[31];
      tc[0].front    <= dn[31];
      tc[0].axis     <= cfg.axis;
      tc[0].ox       <= in_ch.origin_x;
      tc[0].oy       <= in_ch.origin_y;
      tc[0].oz       <= in_ch.origin_z;
      tc[0].dx       <= in_ch.dir_x;
      tc[0].dy       <= in_ch.dir_y;
      tc[0].dz       <= in_ch.dir_z;
      tc[0].far_lim  <= in_ch.far_limit;
      tc[0].near_lim <= cfg.near_lim;
      tc[0].f_lo     <= cfg.f_lo;
      tc[0].f_hi     <= cfg.f_hi;
      tc[0].s_lo     <= cfg.s_lo;
      tc[0].s_hi     <= cfg.s_hi;
      tc[0].mat      <= cfg.mat;
    end
  end

  for (genvar g = 0; g < NT; g++) begin : g_tdiv
    rari_tdiv_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(tv[g]), .din(td[g]), .cin(tc[g]),
      .vout(tv[g+1]), .dout(td[g+1]), .cout(tc[g+1])
    );
  end

  // Stage A: signed t, limit check.
  logic signed [51:0] tq;
  logic               a_v;
  rari_pkg::tctx_t    a_c;
  logic signed [51:0] a_t;
  logic               a_miss;

  always_comb begin
    tq = tc[NT].neg ? -52'(td[NT].num) : 52'(td[NT].num);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= tv[NT];
    end
    if (en) begin
      a_c    <= tc[NT];
      a_t    <= tq;
      a_miss <= tc[NT].miss || tq < 52'(tc[NT].near_lim) || tq > 52'(tc[NT].far_lim);
    end
  end

  // Stage B: products t*dir; t is within 31 bits on any surviving ray.
  logic signed [63:0] b_px, b_py, b_pz;
  logic               b_v, b_miss;
  rari_pkg::tctx_t    b_c;
  logic signed [31:0] b_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
    if (en) begin
      b_c    <= a_c;
      b_miss <= a_miss;
      b_t    <= a_t[31:0];
      b_px   <= $signed(a_t[31:0]) * a_c.dx;
      b_py   <= $signed(a_t[31:0]) * a_c.dy;
      b_pz   <= $signed(a_t[31:0]) * a_c.dz;
    end
  end

  // Stage C: point = origin + floor(prod >> 16); arithmetic shift is floor.
  logic signed [48:0] c_px, c_py, c_pz;
  logic               c_v, c_miss;
  rari_pkg::tctx_t    c_c;
  logic signed [31:0] c_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
    if (en) begin
      c_c    <= b_c;
      c_miss <= b_miss;
      c_t    <= b_t;
      c_px   <= 49'(b_c.ox) + 49'(b_px >>> 16);
      c_py   <= 49'(b_c.oy) + 49'(b_py >>> 16);
      c_pz   <= 49'(b_c.oz) + 49'(b_pz >>> 16);
    end
  end

  // Stage D: bounds check, set up u/v divisions, saturate point.
  logic signed [48:0] pa, pb;
  logic signed [49:0] su, sv, nu, nv;
  logic               inb;
  rari_pkg::udiv_t    ud [0:NU];
  rari_pkg::udiv_t    vd [0:NU];
  rari_pkg::uctx_t    uc [0:NU];
  logic               uv [0:NU];

  function automatic logic signed [31:0] sat(logic signed [48:0] x);
    if (x > 49'sd2147483647) return 32'sh7fffffff;
    if (x < -49'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  always_comb begin
    case (c_c.axis)
      2'd0:    begin pa = c_py; pb = c_pz; end
      2'd1:    begin pa = c_px; pb = c_pz; end
      default: begin pa = c_px; pb = c_py; end
    endcase
    inb = !(pa < 49'(c_c.f_lo) || pa > 49'(c_c.f_hi) ||
            pb < 49'(c_c.s_lo) || pb > 49'(c_c.s_hi));
    su = 50'(c_c.f_hi) - 50'(c_c.f_lo);
    sv = 50'(c_c.s_hi) - 50'(c_c.s_lo);
    // In bounds, p - lo lies in [0, span], so the quotient fits 17 bits.
    nu = 50'(pa) - 50'(c_c.f_lo);
    nv = 50'(pb) - 50'(c_c.s_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uv[0] <= 1'b0;
    end else if (en) begin
      uv[0] <= c_v;
    end
    if (en) begin
      ud[0].rem <= 51'(nu[33:0]) << 16 >> 17;
      ud[0].den <= su;
      vd[0].rem <= 51'(nv[33:0]) << 16 >> 17;
      vd[0].den <= sv;
      // low 17 bits of the dividend enter through num
      ud[0].num <= 17'({nu[0], 16'd0});
      vd[0].num <= 17'({nv[0], 16'd0});
      uc[0].miss  <= c_miss || !inb;
      uc[0].front <= c_c.front;
      uc[0].mat   <= c_c.mat;
      uc[0].t     <= c_t;
      uc[0].px    <= sat(c_px);
      uc[0].py    <= sat(c_py);
      uc[0].pz    <= sat(c_pz);
      uc[0].zu    <= (su <= 0);
      uc[0].zv    <= (sv <= 0);
    end
  end

  for (genvar g = 0; g < NU; g++) begin : g_udiv
    rari_udiv_cell u_cell (
      .clk(clk), .en(en),
      .ui(ud[g]), .vi(vd[g]), .cin(uc[g]),
      .uo(ud[g+1]), .vo(vd[g+1]), .cout(uc[g+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        uv[g+1] <= 1'b0;
      end else if (en) begin
        uv[g+1] <= uv[g];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= uv[NU];
    end
    if (en) begin
      if (uc[NU].miss) begin
        out_ch.hit          <= 1'b0;
        out_ch.distance     <= '0;
        out_ch.coord_u      <= '0;
        out_ch.coord_v      <= '0;
        out_ch.point_x      <= '0;
        out_ch.point_y      <= '0;
        out_ch.point_z      <= '0;
        out_ch.front_face   <= 1'b0;
        out_ch.material_out <= '0;
      end else begin
        out_ch.hit          <= 1'b1;
        out_ch.distance     <= uc[NU].t;
        out_ch.coord_u      <= uc[NU].zu ? '0 : ud[NU].num;
        out_ch.coord_v      <= uc[NU].zv ? '0 : vd[NU].num;
        out_ch.point_x      <= uc[NU].px;
        out_ch.point_y      <= uc[NU].py;
        out_ch.point_z      <= uc[NU].pz;
        out_ch.front_face   <= uc[NU].front;
        out_ch.material_out <= uc[NU].mat;
      end
    end
  end
endmodule

[tb/ray_axis_rect_intersect_top_test.sv]
`timescale 1ns / 100ps

module ray_axis_rect_intersect_top_test;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic [30:0]        far_lim;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic [16:0]        coord_u;
    logic [16:0]        coord_v;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               front_face;
    logic [7:0]         material_out;
  } hit_rec_t;

  // directed rows: ray plus optional typed-in expectation
  typedef struct {
    ray_t     ray;
    bit       fixed;
    hit_rec_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  rari_in_if  in_ch ();
  rari_out_if out_ch ();

  ray_axis_rect_intersect_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // shadow copy of the rectangle registers
  logic [1:0]          sh_axis;
  logic signed [63:0]  sh_f_lo, sh_f_hi, sh_s_lo, sh_s_hi, sh_plane;
  logic [30:0]         sh_near;
  logic [7:0]          sh_mat;

  hit_rec_t pending_hits [$];
  hit_rec_t fixed_want [$];
  bit       fixed_flag [$];
  int       n_errors;
  int       n_rays;
  int       n_hits_seen;
  int       n_results;
  longint   cycle_cnt;
  int       sender_idle_pct;
  int       recv_stall_pct;
  int       hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [63:0] floor_q16(logic signed [63:0] x);
    return x >>> rari_pkg::FB;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [16:0] rect_frac(logic signed [63:0] p, logic signed [63:0] lo,
                                             logic signed [63:0] hi);
    logic signed [63:0] span;
    logic signed [63:0] q;
    span = hi - lo;
    if (span <= 0) return '0;
    q = ((p - lo) * 64'sd65536) / span;
    return q[16:0];
  endfunction

  function automatic hit_rec_t intersect_ray(ray_t r);
    hit_rec_t res;
    int n, a, b;
    logic signed [63:0] org [3];
    logic signed [63:0] dir [3];
    logic signed [63:0] pt [3];
    logic signed [63:0] t;
    res = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      org[i] = r.org[i];
      dir[i] = r.dir[i];
    end
    if (sh_axis == 2'd0) begin
      n = 0; a = 1; b = 2;
    end else if (sh_axis == 2'd1) begin
      n = 1; a = 0; b = 2;
    end else begin
      n = 2; a = 0; b = 1;
    end
    if (dir[n] == 0) return res;
    t = ((sh_plane - org[n]) * 64'sd65536) / dir[n];
    if (t < $signed({33'd0, sh_near}) || t > $signed({33'd0, r.far_lim})) return res;
    for (int i = 0; i < 3; i++) pt[i] = org[i] + floor_q16(t * dir[i]);
    if (pt[a] < sh_f_lo || pt[a] > sh_f_hi || pt[b] < sh_s_lo || pt[b] > sh_s_hi)
      return res;
    res.hit = 1'b1;
    res.distance = t[31:0];
    res.coord_u = rect_frac(pt[a], sh_f_lo, sh_f_hi);
    res.coord_v = rect_frac(pt[b], sh_s_lo, sh_s_hi);
    res.point_x = clamp32(pt[0]);
    res.point_y = clamp32(pt[1]);
    res.point_z = clamp32(pt[2]);
    res.front_face = dir[n] < 0;
    res.material_out = sh_mat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch @%0d result %0d: %s got %0h want %0h", cycle_cnt, n_results, what,
             got, want);
    n_errors++;
  endtask

  // output monitor
  always @(posedge clk) begin
    hit_rec_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        w = pending_hits.pop_front();
        if (out_ch.hit !== w.hit) report_mismatch("hit", out_ch.hit, w.hit);
        if (out_ch.distance !== w.distance)
          report_mismatch("distance", out_ch.distance, w.distance);
        if (out_ch.coord_u !== w.coord_u) report_mismatch("coord_u", out_ch.coord_u, w.coord_u);
        if (out_ch.coord_v !== w.coord_v) report_mismatch("coord_v", out_ch.coord_v, w.coord_v);
        if (out_ch.point_x !== w.point_x) report_mismatch("point_x", out_ch.point_x, w.point_x);
        if (out_ch.point_y !== w.point_y) report_mismatch("point_y", out_ch.point_y, w.point_y);
        if (out_ch.point_z !== w.point_z) report_mismatch("point_z", out_ch.point_z, w.point_z);
        if (out_ch.front_face !== w.front_face)
          report_mismatch("front_face", out_ch.front_face, w.front_face);
        if (out_ch.material_out !== w.material_out)
          report_mismatch("material_out", out_ch.material_out, w.material_out);
        if (out_ch.hit === 1'b1) n_hits_seen++;
      end
      n_results++;
    end
  end

  // receiver back-pressure, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(rari_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rari_pkg::REG_AXIS:  sh_axis = val[1:0];
      rari_pkg::REG_F_LO:  sh_f_lo = $signed(val);
      rari_pkg::REG_F_HI:  sh_f_hi = $signed(val);
      rari_pkg::REG_S_LO:  sh_s_lo = $signed(val);
      rari_pkg::REG_S_HI:  sh_s_hi = $signed(val);
      rari_pkg::REG_PLANE: sh_plane = $signed(val);
      rari_pkg::REG_NEAR:  sh_near = val[30:0];
      rari_pkg::REG_MAT:   sh_mat = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_rect(logic [1:0] ax, logic [31:0] flo, logic [31:0] fhi, logic [31:0] slo,
                          logic [31:0] shi, logic [31:0] pl, logic [31:0] nr, logic [7:0] mt);
    write_reg(rari_pkg::REG_AXIS, {30'd0, ax});
    write_reg(rari_pkg::REG_F_LO, flo);
    write_reg(rari_pkg::REG_F_HI, fhi);
    write_reg(rari_pkg::REG_S_LO, slo);
    write_reg(rari_pkg::REG_S_HI, shi);
    write_reg(rari_pkg::REG_PLANE, pl);
    write_reg(rari_pkg::REG_NEAR, nr);
    write_reg(rari_pkg::REG_MAT, {24'd0, mt});
  endtask

  // inputs are driven at the falling edge; transfer seen at a rising edge with ready high
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.origin_x = r.org[0];
    in_ch.origin_y = r.org[1];
    in_ch.origin_z = r.org[2];
    in_ch.dir_x = r.dir[0];
    in_ch.dir_y = r.dir[1];
    in_ch.dir_z = r.dir[2];
    in_ch.far_limit = r.far_lim;
    do @(posedge clk); while (!in_ch.ready);
    pending_hits.push_back(intersect_ray(r));
    n_rays++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  // rays aimed mostly at the current rectangle so hits are common
  function automatic ray_t aimed_ray();
    ray_t r;
    int n, a, b;
    logic signed [63:0] tgt_a, tgt_b, t;
    if (sh_axis == 2'd0) begin
      n = 0; a = 1; b = 2;
    end else if (sh_axis == 2'd1) begin
      n = 1; a = 0; b = 2;
    end else begin
      n = 2; a = 0; b = 1;
    end
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 3; i++) begin
        r.org[i] = rnd_coord();
        r.dir[i] = ($urandom_range(3) == 0) ? $urandom() : rnd_coord();
      end
      r.far_lim = 31'($urandom());
      return r;
    end
    t = $urandom_range(6 << 16, 1 << 12);
    tgt_a = sh_f_lo + (($urandom_range(1000) * (sh_f_hi - sh_f_lo)) / 1000);
    tgt_b = sh_s_lo + (($urandom_range(1000) * (sh_s_hi - sh_s_lo)) / 1000);
    for (int i = 0; i < 3; i++) r.dir[i] = $signed($urandom_range(4 << 16)) - (2 << 16);
    if (r.dir[n] == 0) r.dir[n] = 32'sd65536;
    r.org[n] = clamp32(sh_plane - floor_q16(t * r.dir[n]));
    r.org[a] = clamp32(tgt_a - floor_q16(t * r.dir[a]));
    r.org[b] = clamp32(tgt_b - floor_q16(t * r.dir[b]));
    r.far_lim = ($urandom_range(4) == 0) ? 31'($urandom_range(32'(t))) : 31'h7fffffff;
    return r;
  endfunction

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz, int fl);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.far_lim = 31'(fl);
    return r;
  endfunction

  row_t rows [$];
  hit_rec_t miss_rec;

  initial begin
    row_t rw;
    hit_rec_t got;
    n_errors = 0; n_rays = 0; n_hits_seen = 0; n_results = 0; cycle_cnt = 0;
    sender_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0; in_ch.far_limit = '0;
    sh_axis = 2'd2; sh_f_lo = 0; sh_f_hi = 65536; sh_s_lo = 0; sh_s_hi = 65536;
    sh_plane = 0; sh_near = 31'd66; sh_mat = 8'd0;
    miss_rec = '{default: '0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, reset rectangle: unit square in xy at z = 0
    rw.fixed = 1'b1; rw.want = miss_rec;
    rw.ray = mk(0, 0, 65536, 0, 0, 0, 32'h7fffffff); rows.push_back(rw);  // zero normal dir
    rw.want = '{1'b1, 32'sd65536, 17'd32768, 17'd32768, 32'sd32768, 32'sd32768, 32'sd0,
                1'b1, 8'd0};
    rw.ray = mk(32768, 32768, 65536, 0, 0, -65536, 32'h7fffffff); rows.push_back(rw);
    rw.want = miss_rec;
    rw.ray = mk(32768, 32768, 65536, 0, 0, -65536, 1000); rows.push_back(rw);  // beyond far
    rw.ray = mk(32768, 32768, 65536, 0, 0, 65536, 32'h7fffffff); rows.push_back(rw);  // behind
    rw.ray = mk(32'h7fffffff, 32'h80000000, 65536, 0, 0, -65536, 32'h7fffffff);
    rows.push_back(rw);
    rw.want = '{1'b1, 32'sd65536, 17'd65536, 17'd0, 32'sd65536, 32'sd0, 32'sd0, 1'b0, 8'd0};
    rw.ray = mk(65536, 0, -65536, 0, 0, 65536, 32'h7fffffff); rows.push_back(rw);  // corner
    rw.fixed = 1'b0;
    rw.ray = mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'h7fffffff); rows.push_back(rw);
    rw.ray = mk(1000, 2000, 100, 300, -400, -1, 32'h7fffffff); rows.push_back(rw);
    rw.ray = mk(-1, -1, -1, -1, -1, 1, 32'h7fffffff); rows.push_back(rw);
    foreach (rows[i]) begin
      send_ray(rows[i].ray);
      if (rows[i].fixed) begin
        got = pending_hits[$];
        if (got != rows[i].want) report_mismatch("predictor row", i, 0);
        pending_hits[$] = rows[i].want;
      end
    end
    drain();

    // zero-width rectangle, x normal, huge plane
    set_rect(2'd0, 32'h00010000, 32'h00010000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
             32'd0, 8'hff);
    for (int i = 0; i < 8; i++) send_ray(aimed_ray());
    send_ray(mk(0, 65536, 0, 65536, 0, 7, 32'h7fffffff));
    drain();
    set_rect(2'd3, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 8'h5a);
    for (int i = 0; i < 8; i++) send_ray(aimed_ray());
    drain();

    // random phases across idling patterns and rectangle settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      set_rect(2'($urandom_range(3)), -($urandom_range(4 << 16)), $urandom_range(4 << 16),
               -($urandom_range(4 << 16)), ($urandom_range(3) == 0) ? 0 : $urandom_range(4 << 16),
               rnd_coord(), $urandom_range(3) == 0 ? 0 : $urandom_range(1 << 14),
               8'($urandom_range(255)));
      if (ph == 4) hold_off_cycles = 400;  // pipeline fills, input stalls
      for (int i = 0; i < 72; i++) send_ray(aimed_ray());
      if (ph == 6) begin
        // sender waits for everything outstanding before continuing
        while (pending_hits.size() != 0) @(negedge clk);
        for (int i = 0; i < 10; i++) send_ray(aimed_ray());
      end
      drain();
    end

    $display("covered %0d rays (%0d hits) over all normal axes, limits and stall patterns",
             n_rays, n_hits_seen);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
